// ===== src/itda_pkg.sv =====
// Shared types and constants for the decimal ASCII converter.
// Used by the controller, the datapath, the top level and the checker.
package itda_pkg;

  localparam int DEFAULT_VALUE_WIDTH = 32;
  localparam int VALUE_BITS          = 32;
  localparam int CHAR_BITS           = 8;
  localparam int BITS_PER_STEP       = 4;

  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;

  typedef struct packed {
    logic load;
    logic step;
    logic find;
    logic dec;
    logic sign_sel;
  } itda_cmd_t;

  typedef struct packed {
    logic neg;
    logic last_digit;
  } itda_status_t;

endpackage

// ===== src/itda_datapath.sv =====
// Datapath: magnitude register, shift-and-add-3 BCD converter and digit selector.
// Depends on itda_pkg; driven by itda_ctrl through itda_cmd_t.
module itda_datapath import itda_pkg::*; #(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic                  clk,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  is_signed,
  input  itda_cmd_t             cmd,
  output itda_status_t          status,
  output logic [CHAR_BITS-1:0]  character
);

  localparam int STEPS = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PW    = STEPS * BITS_PER_STEP;
  localparam int ND    = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int ND_W  = $clog2(ND);

  logic [PW-1:0]         mag;
  logic [ND-1:0][3:0]    bcd;
  logic                  neg;
  logic [ND_W-1:0]       idx;

  logic [VALUE_WIDTH-1:0] v;
  logic                   neg_in;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic [ND-1:0][3:0]     b_next;
  logic [PW-1:0]          m_next;
  logic [ND_W-1:0]        top;

  always_comb begin
    v      = VALUE_WIDTH'(value);
    neg_in = is_signed & v[VALUE_WIDTH-1];
    mag_in = neg_in ? (~v + VALUE_WIDTH'(1)) : v;
  end

  always_comb begin
    b_next = bcd;
    m_next = mag;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < ND; d++) begin
        if (b_next[d] >= 4'd5) begin
          b_next[d] = b_next[d] + 4'd3;
        end
      end
      {b_next, m_next} = {b_next, m_next} << 1;
    end
  end

  always_comb begin
    top = '0;
    for (int d = 0; d < ND; d++) begin
      if (bcd[d] != 4'd0) begin
        top = ND_W'(d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= PW'(mag_in);
      bcd <= '0;
      neg <= neg_in;
    end else if (cmd.step) begin
      mag <= m_next;
      bcd <= b_next;
    end
    if (cmd.find) begin
      idx <= top;
    end else if (cmd.dec) begin
      idx <= idx - ND_W'(1);
    end
  end

  assign status.neg        = neg;
  assign status.last_digit = (idx == '0);
  assign character = cmd.sign_sel ? CH_MINUS : (CH_ZERO + {4'd0, bcd[idx]});

endmodule

// ===== src/itda_ctrl.sv =====
// Controller: sequences load, conversion steps, leading-digit search and output beats.
// Depends on itda_pkg; commands itda_datapath.
module itda_ctrl import itda_pkg::*; #(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  itda_status_t status,
  output itda_cmd_t    cmd
);

  localparam int STEPS  = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_FIND,
    S_SIGN,
    S_DIGIT
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] cnt;

  assign in_ready     = (state == S_IDLE);
  assign out_valid    = (state == S_SIGN) || (state == S_DIGIT);
  assign cmd.load     = (state == S_IDLE) && in_valid;
  assign cmd.step     = (state == S_CONV);
  assign cmd.find     = (state == S_FIND);
  assign cmd.dec      = (state == S_DIGIT) && out_ready;
  assign cmd.sign_sel = (state == S_SIGN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (in_valid) begin
            state <= S_CONV;
          end
        end
        S_CONV: begin
          cnt <= cnt + STEP_W'(1);
          if (cnt == STEP_W'(STEPS - 1)) begin
            state <= S_FIND;
          end
        end
        S_FIND: begin
          state <= status.neg ? S_SIGN : S_DIGIT;
        end
        S_SIGN: begin
          if (out_ready) begin
            state <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (out_ready && status.last_digit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/integer_to_decimal_ascii_top.sv =====
// Top level of the binary to decimal ASCII converter.
// Depends on itda_pkg, itda_ctrl and itda_datapath.
//
// Usage: an input beat carries value and is_signed; the block answers with one
// output beat per character, most significant first: a minus sign for a
// negative signed value, then the digits without leading zeros. The final
// character of a number has last set; no terminator follows.
// Only the low VALUE_WIDTH bits of value are used.
// One number is handled at a time: in_ready is high only while idle.
// Conversion runs a shift-and-add-3 unit four bits per cycle; after the input
// beat it runs the conversion steps, then searches for the leading digit, and
// then offers the characters, which follow one per cycle while out_ready
// is high.
// When the receiver stalls, character and last hold until the beat is taken.
// Synchronous reset returns the block to idle and drops any number in progress.
module integer_to_decimal_ascii_top import itda_pkg::*; #(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                 is_signed,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CHAR_BITS-1:0] character,
  output logic                 last
);

  itda_cmd_t    cmd;
  itda_status_t status;

  itda_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  itda_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .value     (value),
    .is_signed (is_signed),
    .cmd       (cmd),
    .status    (status),
    .character (character)
  );

  assign last = !cmd.sign_sel && status.last_digit;

endmodule

// ===== src/itda_checker.sv =====
// Port-level checker for the decimal ASCII converter, bound to the top level.
// Depends on itda_pkg.
module itda_checker import itda_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CHAR_BITS-1:0] character,
  input logic                 last
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
    else $error("Output beat changed while stalled.");

  a_char_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (character == CH_MINUS) ||
                  ((character >= CH_ZERO) && (character <= CH_NINE)))
    else $error("Character is neither a digit nor a minus sign.");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (character == CH_MINUS) |-> !last)
    else $error("Minus sign flagged as last.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("Input taken while characters are pending.");

  a_single_minus: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && (character == CH_MINUS) |=>
      !(out_valid && (character == CH_MINUS)))
    else $error("Two minus signs in a row.");

endmodule

bind integer_to_decimal_ascii_top itda_checker u_itda_checker (.*);

// ===== test/integer_to_decimal_ascii_top_tb.sv =====
// Self-checking testbench for integer_to_decimal_ascii_top: drives numbers in and checks the
// decimal ASCII characters that come back against a predictor of the conversion.
// Depends on itda_pkg and the integer_to_decimal_ascii_top RTL.
module integer_to_decimal_ascii_top_tb;
  import itda_pkg::*;

  localparam int WORD_WIDTH = DEFAULT_VALUE_WIDTH;
  localparam int DIR_ROWS   = 20;
  localparam int TIMEOUT    = 5_000_000;

  typedef struct packed {
    logic [CHAR_BITS-1:0] ch;
    logic                 last;
  } char_beat_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [VALUE_BITS-1:0] value;
  logic                  is_signed;
  logic                  out_valid;
  logic                  out_ready;
  logic [CHAR_BITS-1:0]  character;
  logic                  last;

  char_beat_t  awaited_chars[$];
  char_beat_t  due_beat;
  string       pending_text;
  int          mismatch_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  logic [VALUE_BITS-1:0] dir_word [DIR_ROWS] = '{
    32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0009, 32'h0000_000A,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
    32'h7FFF_FFFF, 32'h8000_0001, 32'hFFFF_FFF6, 32'h3B9A_CA00, 32'h3B9A_C9FF,
    32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h1234_5678, 32'hDEAD_BEEF
  };
  bit dir_signed [DIR_ROWS] = '{
    0, 1, 0, 0, 0,
    0, 1, 1, 0, 1,
    0, 1, 1, 0, 0,
    1, 1, 0, 0, 1
  };
  string dir_text [DIR_ROWS] = '{
    "0", "0", "1", "9", "10",
    "4294967295", "-1", "-2147483648", "2147483648", "2147483647",
    "2147483647", "-2147483647", "-10", "1000000000", "999999999",
    "", "", "", "", ""
  };

  integer_to_decimal_ascii_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .is_signed (is_signed),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last      (last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Queues the characters of one number: from the typed text where a row gives one,
  // otherwise from the conversion worked out here.
  function automatic void queue_number_text(input logic [VALUE_BITS-1:0] raw,
                                            input logic signed_mode, input string typed);
    logic [63:0]          mask;
    logic [63:0]          magnitude;
    logic                 negative;
    logic [CHAR_BITS-1:0] digits[$];
    mask = (WORD_WIDTH >= 64) ? '1 : ((64'd1 << WORD_WIDTH) - 64'd1);
    if (typed.len() != 0) begin
      for (int i = 0; i < typed.len(); i++) begin
        awaited_chars.push_back('{ch: typed[i], last: (i == typed.len() - 1)});
      end
    end else begin
      magnitude = 64'(raw) & mask;
      negative  = signed_mode && magnitude[WORD_WIDTH-1];
      if (negative) begin
        magnitude = (~magnitude + 64'd1) & mask;
      end
      do begin
        digits.push_front(CH_ZERO + CHAR_BITS'(magnitude % 64'd10));
        magnitude = magnitude / 64'd10;
      end while (magnitude != 64'd0);
      if (negative) begin
        awaited_chars.push_back('{ch: CH_MINUS, last: 1'b0});
      end
      foreach (digits[i]) begin
        awaited_chars.push_back('{ch: digits[i], last: (i == digits.size() - 1)});
      end
    end
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value();
    logic [VALUE_BITS-1:0] word;
    int unsigned           exponent;
    exponent = $urandom_range(9);
    case ($urandom_range(5))
      0: word = $urandom;
      1: word = $urandom_range(99);
      2: begin
        word = 1;
        repeat (exponent) word = word * 10;
        word = word - $urandom_range(1);
      end
      3: word = 32'd0 - $urandom_range(99);
      4: word = (($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFC) + $urandom_range(3);
      default: word = $urandom >> $urandom_range(31);
    endcase
    return word;
  endfunction

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_number(input logic [VALUE_BITS-1:0] word, input logic signed_mode,
                             input string typed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    value        <= word;
    is_signed    <= signed_mode;
    pending_text <= typed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        queue_number_text(value, is_signed, pending_text);
      end
      if (out_valid && out_ready) begin
        if (awaited_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character %h last %b", character, last));
        end else begin
          due_beat = awaited_chars.pop_front();
          if (character !== due_beat.ch) begin
            report_mismatch($sformatf("character %h, wanted %h", character, due_beat.ch));
          end
          if (last !== due_beat.last) begin
            report_mismatch($sformatf("last %b on %h, wanted %b", last, character,
                                      due_beat.last));
          end
        end
      end
    end
  end

  initial begin
    int guard;
    rst            = 1'b1;
    in_valid       = 1'b0;
    value          = '0;
    is_signed      = 1'b0;
    out_ready      = 1'b0;
    pending_text   = "";
    mismatch_count = 0;
    send_idle_pct  = 35;
    recv_idle_pct  = 62;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_number(dir_word[r], dir_signed[r], dir_text[r]);
    end
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 62;
        end
        1: begin
          send_idle_pct = 62;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (120) send_number(pick_value(), 1'($urandom_range(1)), "");
    end
    in_valid <= 1'b0;

    guard = 0;
    while (awaited_chars.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    if (awaited_chars.size() != 0) begin
      report_mismatch($sformatf("%0d characters never arrived", awaited_chars.size()));
    end

    if (mismatch_count == 0) begin
      $display("integer_to_decimal_ascii_top_tb passed");
    end else begin
      $display("integer_to_decimal_ascii_top_tb failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("integer_to_decimal_ascii_top_tb failed");
    $finish;
  end

endmodule
